// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is active.
`define DPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define DPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/dpm_pkg.sv =====
package dpm_pkg;

  localparam int CodeW  = 12;
  localparam int InW    = 16;
  localparam int QuotW  = 10;
  localparam int DivW   = 23;
  localparam int ChanW  = 8;
  localparam int ApbW   = 32;
  localparam int AddrW  = 3;
  localparam int RegIdxW = AddrW - 2;

  localparam logic [QuotW-1:0] PosFull = QuotW'(1009);

  localparam logic [CodeW-1:0] LowReset  = CodeW'(0);
  localparam logic [CodeW-1:0] HighReset = CodeW'(640);

  localparam logic [RegIdxW-1:0] RegLow  = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegHigh = RegIdxW'(1);

  typedef struct packed {
    logic [CodeW-1:0] low;
    logic [CodeW-1:0] high;
  } cfg_t;

  typedef struct packed {
    logic [QuotW-1:0] quot;
    logic             black;
    logic             sat;
    logic             eof;
  } div_res_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             frame_end;
  } pix_t;

endpackage

// ===== src/dpm_cfg_regs.sv =====
module dpm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpm_pkg::AddrW-1:0]     paddr,
  input  logic [dpm_pkg::ApbW-1:0]      pwdata,
  output logic [dpm_pkg::ApbW-1:0]      prdata,
  output logic                          pready,
  output dpm_pkg::cfg_t                 cfg_o
);

  logic [dpm_pkg::CodeW-1:0] low_q, low_d;
  logic [dpm_pkg::CodeW-1:0] high_q, high_d;
  logic                      wr_en;
  logic [dpm_pkg::RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[dpm_pkg::AddrW-1:2];

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (wr_en) begin
      unique case (reg_idx)
        dpm_pkg::RegLow:  low_d  = pwdata[dpm_pkg::CodeW-1:0];
        dpm_pkg::RegHigh: high_d = pwdata[dpm_pkg::CodeW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dpm_pkg::RegLow:  prdata = dpm_pkg::ApbW'(low_q);
      dpm_pkg::RegHigh: prdata = dpm_pkg::ApbW'(high_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= dpm_pkg::LowReset;
      high_q <= dpm_pkg::HighReset;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign cfg_o.low  = low_q;
  assign cfg_o.high = high_q;

endmodule

// ===== src/dpm_divider.sv =====
module dpm_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dpm_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [dpm_pkg::CodeW-1:0] code_i,
  input  logic                      eof_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dpm_pkg::div_res_t         res_o
);

  localparam int Stages = dpm_pkg::QuotW + 1;

  typedef struct packed {
    logic [dpm_pkg::DivW-1:0]  rem;
    logic [dpm_pkg::QuotW-1:0] quot;
    logic                      black;
    logic                      sat;
    logic                      eof;
  } stage_t;

  stage_t              st_q [Stages];
  stage_t              st_d [Stages];
  logic [Stages-1:0]   vld_q;
  logic [Stages-1:0]   vin;
  logic [Stages:0]     rdy;

  assign vin = {vld_q[Stages-2:0], in_valid_i};

  always_comb begin
    rdy[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    logic [dpm_pkg::DivW-1:0] dsh;
    dsh = '0;
    st_d[0].rem   = dpm_pkg::DivW'(code_i) * dpm_pkg::DivW'(dpm_pkg::PosFull);
    st_d[0].quot  = '0;
    st_d[0].black = (code_i <= cfg_i.low);
    st_d[0].sat   = (code_i >= cfg_i.high);
    st_d[0].eof   = eof_i;
    for (int k = 1; k < Stages; k++) begin
      dsh     = dpm_pkg::DivW'(cfg_i.high) << (Stages - 1 - k);
      st_d[k] = st_q[k-1];
      if (st_q[k-1].rem >= dsh) begin
        st_d[k].rem  = st_q[k-1].rem - dsh;
        st_d[k].quot = st_q[k-1].quot | (dpm_pkg::QuotW'(1) << (Stages - 1 - k));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (rdy[k] && vin[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Stages-1];
  assign res_o.quot  = st_q[Stages-1].quot;
  assign res_o.black = st_q[Stages-1].black;
  assign res_o.sat   = st_q[Stages-1].sat;
  assign res_o.eof   = st_q[Stages-1].eof;

endmodule

// ===== src/dpm_color.sv =====
module dpm_color (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dpm_pkg::div_res_t res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dpm_pkg::pix_t     pix_o
);

  localparam int PosW = dpm_pkg::QuotW;
  localparam int DW   = dpm_pkg::ChanW;
  localparam int XW   = 14;
  localparam int PW   = 16;
  localparam int RW   = 29;

  localparam logic [PosW-1:0] Bp1 = PosW'(64);
  localparam logic [PosW-1:0] Bp2 = PosW'(249);
  localparam logic [PosW-1:0] Bp3 = PosW'(377);
  localparam logic [PosW-1:0] Bp4 = PosW'(632);
  localparam logic [PosW-1:0] Bp5 = PosW'(696);
  localparam logic [PosW-1:0] Bp6 = PosW'(881);

  localparam logic [DW-1:0] Full  = DW'(255);
  localparam logic [XW-1:0] Mul51 = XW'(51);
  localparam logic [RW-1:0] Recip = RW'(28340);

  typedef enum logic [2:0] {
    SegBlueIn,
    SegRedIn,
    SegBlueBack,
    SegGreenIn,
    SegBlueAgain,
    SegRedAgain,
    SegRedFull
  } seg_e;

  typedef struct packed {
    logic [PosW-1:0] pos;
    seg_e            seg;
    logic            eof;
  } s1_t;

  typedef struct packed {
    seg_e          seg;
    logic [DW-1:0] dr;
    logic [DW-1:0] df;
    logic [XW-1:0] xr;
    logic [XW-1:0] xf;
    logic          eof;
  } s2_t;

  s1_t           s1_q, s1_d;
  s2_t           s2_q, s2_d;
  dpm_pkg::pix_t s3_q, s3_d;
  logic          v1_q, v2_q, v3_q;
  logic          rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  always_comb begin
    if (res_i.black) begin
      s1_d.pos = '0;
    end else if (res_i.sat) begin
      s1_d.pos = dpm_pkg::PosFull;
    end else begin
      s1_d.pos = res_i.quot;
    end
    if (s1_d.pos < Bp1) begin
      s1_d.seg = SegBlueIn;
    end else if (s1_d.pos < Bp2) begin
      s1_d.seg = SegRedIn;
    end else if (s1_d.pos < Bp3) begin
      s1_d.seg = SegBlueBack;
    end else if (s1_d.pos < Bp4) begin
      s1_d.seg = SegGreenIn;
    end else if (s1_d.pos < Bp5) begin
      s1_d.seg = SegBlueAgain;
    end else if (s1_d.pos < Bp6) begin
      s1_d.seg = SegRedAgain;
    end else begin
      s1_d.seg = SegRedFull;
    end
    s1_d.eof = res_i.eof;
  end

  always_comb begin
    logic [PosW-1:0] seg_lo;
    logic [PosW-1:0] seg_hi;
    logic [PosW-1:0] rise_w;
    logic [PosW-1:0] fall_w;
    unique case (s1_q.seg)
      SegBlueIn:    begin seg_lo = '0;  seg_hi = Bp1; end
      SegRedIn:     begin seg_lo = Bp1; seg_hi = Bp2; end
      SegBlueBack:  begin seg_lo = Bp2; seg_hi = Bp3; end
      SegGreenIn:   begin seg_lo = Bp3; seg_hi = Bp4; end
      SegBlueAgain: begin seg_lo = Bp4; seg_hi = Bp5; end
      SegRedAgain:  begin seg_lo = Bp5; seg_hi = Bp6; end
      default:      begin seg_lo = Bp6; seg_hi = dpm_pkg::PosFull; end
    endcase
    rise_w   = s1_q.pos - seg_lo;
    fall_w   = seg_hi - s1_q.pos;
    s2_d.seg = s1_q.seg;
    s2_d.dr  = rise_w[DW-1:0];
    s2_d.df  = fall_w[DW-1:0];
    s2_d.xr  = XW'(rise_w[DW-1:0]) * Mul51;
    s2_d.xf  = XW'(fall_w[DW-1:0]) * Mul51;
    s2_d.eof = s1_q.eof;
  end

  always_comb begin
    logic [PW-1:0] p255;
    logic [RW-1:0] pr;
    logic [RW-1:0] pf;
    logic [DW-1:0] r64;
    logic [DW-1:0] r128;
    logic [DW-1:0] r185;
    logic [DW-1:0] f185;
    p255 = PW'(s2_q.dr) * PW'(Full);
    pr   = RW'(s2_q.xr) * Recip;
    pf   = RW'(s2_q.xf) * Recip;
    r64  = p255[13:6];
    r128 = p255[14:7];
    r185 = pr[27:20];
    f185 = pf[27:20];
    s3_d.blue      = '0;
    s3_d.green     = '0;
    s3_d.red       = '0;
    s3_d.frame_end = s2_q.eof;
    unique case (s2_q.seg)
      SegBlueIn: begin
        s3_d.blue = r64;
      end
      SegRedIn: begin
        s3_d.blue = f185;
        s3_d.red  = r185;
      end
      SegBlueBack: begin
        s3_d.blue = r128;
        s3_d.red  = Full;
      end
      SegGreenIn: begin
        s3_d.blue  = s2_q.df;
        s3_d.green = s2_q.dr;
        s3_d.red   = s2_q.df;
      end
      SegBlueAgain: begin
        s3_d.blue  = r64;
        s3_d.green = Full;
      end
      SegRedAgain: begin
        s3_d.blue  = f185;
        s3_d.green = Full;
        s3_d.red   = r185;
      end
      default: begin
        s3_d.red = Full;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;
  assign pix_o       = s3_q;

endmodule

// ===== src/disparity_pseudocolor_map_unit.sv =====
// Disparity pseudocolor map: each 16-bit disparity word on the input stream becomes one blue,
// green and red pixel on the output stream, with tlast passed along. Only the low 12 bits of
// the word are used. Codes at or below the low limit register (byte address 0) give black,
// codes at or above the high limit register (byte address 4) give full red, and codes in
// between are scaled by 1009 over the high limit and mapped through a seven-segment color ramp.
// The block takes one pixel every clock while the output is not stalled; each pixel passes
// through the divider's entry stage, the ten one-bit-per-stage divider stages behind it and
// the three color stages. Both limits read back over the same port, and they should be changed
// only while no pixel is in flight.
module disparity_pseudocolor_map_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0: raw_disparity[15:0].
  input  logic [dpm_pkg::InW-1:0]    s_axis_tdata,
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // Fields from bit 0: blue[7:0], green[15:8], red[23:16].
  output logic [3*dpm_pkg::ChanW-1:0] m_axis_tdata,
  output logic                       m_axis_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpm_pkg::AddrW-1:0]  paddr,
  input  logic [dpm_pkg::ApbW-1:0]   pwdata,
  output logic [dpm_pkg::ApbW-1:0]   prdata,
  output logic                       pready
);

  dpm_pkg::cfg_t     cfg;
  dpm_pkg::div_res_t div_res;
  dpm_pkg::pix_t     pix;
  logic              div_valid;
  logic              div_ready;

  dpm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dpm_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .code_i      (s_axis_tdata[dpm_pkg::CodeW-1:0]),
    .eof_i       (s_axis_tlast),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .res_o       (div_res)
  );

  dpm_color u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .res_i       (div_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pix_o       (pix)
  );

  assign m_axis_tdata = {pix.red, pix.green, pix.blue};
  assign m_axis_tlast = pix.frame_end;

endmodule

// ===== src/dpm_checker.sv =====
`include "assert_macros.svh"

module dpm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [3*dpm_pkg::ChanW-1:0] m_axis_tdata,
  input logic                        m_axis_tlast,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [dpm_pkg::AddrW-1:0]   paddr,
  input logic [dpm_pkg::ApbW-1:0]    pwdata,
  input logic [dpm_pkg::ApbW-1:0]    prdata,
  input logic                        pready
);

  logic                        cfg_wr;
  logic                        out_stall;
  logic [3*dpm_pkg::ChanW:0]   out_word;
  logic [dpm_pkg::RegIdxW-1:0] rd_idx;
  logic [dpm_pkg::CodeW-1:0]   wr_val;
  logic [dpm_pkg::CodeW-1:0]   rd_val;

  assign cfg_wr    = psel && penable && pwrite && pready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tdata};
  assign rd_idx    = paddr[dpm_pkg::AddrW-1:2];
  assign wr_val    = pwdata[dpm_pkg::CodeW-1:0];
  assign rd_val    = prdata[dpm_pkg::CodeW-1:0];

  property p_readback;
    $past(rst_ni && cfg_wr) && (rd_idx == $past(rd_idx)) |-> rd_val == $past(wr_val);
  endproperty

  `DPM_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

  `DPM_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled output changed")

  `DPM_ASSERT(a_readback, p_readback, "register readback differs from the last write")

  `DPM_ASSERT(a_read_upper_zero, prdata[dpm_pkg::ApbW-1:dpm_pkg::CodeW] == '0, "read bits set")

endmodule

bind disparity_pseudocolor_map_unit dpm_checker u_dpm_checker (.*);
